// ===== rtl/core/urch_pkg.sv =====
package urch_pkg;

   // Widths of the item fields.
   localparam int unsigned OP_W     = 2;
   localparam int unsigned COORD_W  = 4;
   localparam int unsigned VALUE_W  = 4;
   localparam int unsigned COUNT_W  = 6;
   localparam int unsigned STATUS_W = 2;

   // One history word: row, column, old value, new value.
   localparam int unsigned ENTRY_W  = 2 * COORD_W + 2 * VALUE_W;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PLACE = 2'd0;
   localparam logic [OP_W-1:0] OP_UNDO  = 2'd1;
   localparam logic [OP_W-1:0] OP_REDO  = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

endpackage

// ===== rtl/core/urch_grid.sv =====
// Cell store: a synchronous memory with a registered read port and a
// valid bit per cell, so that a cell never written reads as empty.
module urch_grid #(
   parameter int unsigned CELLS = 81,
   localparam int unsigned IW = $clog2(CELLS)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [IW-1:0]               rd_idx,
   input  logic                        wr_en,
   input  logic [IW-1:0]               wr_idx,
   input  logic [urch_pkg::VALUE_W-1:0] wr_data,
   output logic [urch_pkg::VALUE_W-1:0] rd_data
);

   logic [urch_pkg::VALUE_W-1:0] mem [CELLS];
   logic [CELLS-1:0]             valid_ff;
   logic [CELLS-1:0]             valid_in;
   logic [urch_pkg::VALUE_W-1:0] rd_q_ff;
   logic                         rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

// ===== rtl/core/undo_redo_cell_history.sv =====
// Place and read: one word after the accept and the cell read; invalid
// requests, zero counts and empty undo or redo answer in the next cycle.
// An undo or redo run of n steps gives n words, one per step (history
// read, then cell read-modify-write). The receiver cannot stall; busy
// blocks new requests until the last word. Synchronous reset empties the
// grid through per-cell valid bits and clears cursor and length.
module undo_redo_cell_history #(
   parameter int unsigned HISTORY_DEPTH = 256,
   parameter int unsigned GRID_SIDE     = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [urch_pkg::OP_W-1:0]     req_op,
   input  logic [urch_pkg::COORD_W-1:0]  req_row,
   input  logic [urch_pkg::COORD_W-1:0]  req_col,
   input  logic [urch_pkg::VALUE_W-1:0]  req_new_value,
   input  logic [urch_pkg::COUNT_W-1:0]  req_count,
   output logic                          rsp_strobe,
   output logic [urch_pkg::STATUS_W-1:0] rsp_status,
   output logic [urch_pkg::COORD_W-1:0]  rsp_cell_row,
   output logic [urch_pkg::COORD_W-1:0]  rsp_cell_col,
   output logic [urch_pkg::VALUE_W-1:0]  rsp_value_before,
   output logic [urch_pkg::VALUE_W-1:0]  rsp_value_after,
   output logic [urch_pkg::COUNT_W-1:0]  rsp_step_number,
   output logic                          rsp_ran_short,
   output logic                          rsp_last
);

   localparam int unsigned CELLS = GRID_SIDE * GRID_SIDE;
   localparam int unsigned IW    = $clog2(CELLS);
   localparam int unsigned AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int unsigned CW    = $clog2(HISTORY_DEPTH + 1);
   localparam int unsigned MW    = (CW > urch_pkg::COUNT_W) ? CW : urch_pkg::COUNT_W;
   localparam int unsigned CRD   = urch_pkg::COORD_W;
   localparam int unsigned VW    = urch_pkg::VALUE_W;
   localparam int unsigned NW    = urch_pkg::COUNT_W;

   // The sequencer: S_CELL finishes a place or read once the cell data is
   // back; S_HIST and S_GRID alternate for each undo or redo step.
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CELL = 4'b0010,
      S_HIST = 4'b0100,
      S_GRID = 4'b1000
   } state_type;

   // Cell number from row and column; an index at or past CELLS maps to cell 0.
   function automatic logic [IW-1:0] cell_index(input logic [CRD-1:0] r,
                                                input logic [CRD-1:0] c);
      logic [9:0] full;
      full = 10'(r) * 10'(GRID_SIDE) + 10'(c);
      return (full < 10'(CELLS)) ? full[IW-1:0] : '0;
   endfunction

   state_type         state_ff, state_in;
   logic              is_place_ff, is_place_in;
   logic              is_undo_ff, is_undo_in;
   logic [CRD-1:0]    row_ff, row_in;
   logic [CRD-1:0]    col_ff, col_in;
   logic [VW-1:0]     val_ff, val_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [CW-1:0]     length_ff, length_in;
   logic [NW-1:0]     nsteps_ff, nsteps_in;
   logic [NW-1:0]     step_ff, step_in;
   logic              short_ff, short_in;
   logic [CRD-1:0]    ent_row_ff, ent_row_in;
   logic [CRD-1:0]    ent_col_ff, ent_col_in;
   logic [VW-1:0]     ent_old_ff, ent_old_in;
   logic [VW-1:0]     ent_new_ff, ent_new_in;

   // Result word registers.
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [urch_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CRD-1:0]                rsp_row_ff, rsp_row_in;
   logic [CRD-1:0]                rsp_col_ff, rsp_col_in;
   logic [VW-1:0]                 rsp_before_ff, rsp_before_in;
   logic [VW-1:0]                 rsp_after_ff, rsp_after_in;
   logic [NW-1:0]                 rsp_step_ff, rsp_step_in;
   logic                          rsp_short_ff, rsp_short_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Grid memory port.
   logic          g_rd_en;
   logic [IW-1:0] g_rd_idx;
   logic          g_wr_en;
   logic [IW-1:0] g_wr_idx;
   logic [VW-1:0] g_wr_data;
   logic [VW-1:0] g_rd_data;

   // History memory.
   logic [urch_pkg::ENTRY_W-1:0] hist_mem [HISTORY_DEPTH];
   logic                         hist_rd_en;
   logic [AW-1:0]                hist_rd_addr;
   logic                         hist_wr_en;
   logic [AW-1:0]                hist_wr_addr;
   logic [urch_pkg::ENTRY_W-1:0] hist_wr_data;
   logic [urch_pkg::ENTRY_W-1:0] hist_rdata_ff;

   // Request decode.
   logic          accepted;
   logic          addr_ok;
   logic          digit_ok;
   logic [MW-1:0] avail;
   logic [MW-1:0] count_w;
   logic [MW-1:0] nsel;
   logic          step_done;
   logic [VW-1:0] step_after;

   urch_grid #(
      .CELLS(CELLS)
   ) u_grid (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (g_rd_en),
      .rd_idx  (g_rd_idx),
      .wr_en   (g_wr_en),
      .wr_idx  (g_wr_idx),
      .wr_data (g_wr_data),
      .rd_data (g_rd_data)
   );

   assign busy     = (state_ff != S_IDLE);
   assign accepted = start && !busy;
   assign addr_ok  = ({1'b0, req_row} < 5'(GRID_SIDE)) && ({1'b0, req_col} < 5'(GRID_SIDE));
   assign digit_ok = ({1'b0, req_new_value} <= 5'(GRID_SIDE));

   // Undo may go back as far as the cursor; redo as far as the recorded length.
   assign avail   = (req_op == urch_pkg::OP_UNDO) ? MW'(cursor_ff)
                                                  : MW'(length_ff - cursor_ff);
   assign count_w = MW'(req_count);
   assign nsel    = (avail < count_w) ? avail : count_w;

   assign step_done  = (step_ff == nsteps_ff);
   assign step_after = is_undo_ff ? ent_old_ff : ent_new_ff;

   always_comb begin
      state_in    = state_ff;
      is_place_in = is_place_ff;
      is_undo_in  = is_undo_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      val_in      = val_ff;
      idx_in      = idx_ff;
      cursor_in   = cursor_ff;
      length_in   = length_ff;
      nsteps_in   = nsteps_ff;
      step_in     = step_ff;
      short_in    = short_ff;
      ent_row_in  = ent_row_ff;
      ent_col_in  = ent_col_ff;
      ent_old_in  = ent_old_ff;
      ent_new_in  = ent_new_ff;

      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_before_in = rsp_before_ff;
      rsp_after_in  = rsp_after_ff;
      rsp_step_in   = rsp_step_ff;
      rsp_short_in  = rsp_short_ff;
      rsp_last_in   = rsp_last_ff;

      g_rd_en      = 1'b0;
      g_rd_idx     = cell_index(req_row, req_col);
      g_wr_en      = 1'b0;
      g_wr_idx     = idx_ff;
      g_wr_data    = val_ff;
      hist_rd_en   = 1'b0;
      hist_rd_addr = (req_op == urch_pkg::OP_UNDO) ? AW'(cursor_ff - CW'(1)) : AW'(cursor_ff);
      hist_wr_en   = 1'b0;
      hist_wr_addr = AW'(cursor_ff);
      hist_wr_data = {row_ff, col_ff, g_rd_data, val_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accepted) begin
               row_in = req_row;
               col_in = req_col;
               val_in = req_new_value;
               idx_in = cell_index(req_row, req_col);
               // Default to a single finished word; the cases below override.
               rsp_strobe_in = 1'b1;
               rsp_status_in = urch_pkg::ST_OK;
               rsp_row_in    = '0;
               rsp_col_in    = '0;
               rsp_before_in = '0;
               rsp_after_in  = '0;
               rsp_step_in   = '0;
               rsp_short_in  = 1'b0;
               rsp_last_in   = 1'b1;
               unique case (req_op)
                  urch_pkg::OP_PLACE, urch_pkg::OP_READ: begin
                     if (addr_ok && (digit_ok || req_op == urch_pkg::OP_READ)) begin
                        rsp_strobe_in = 1'b0;
                        is_place_in   = (req_op == urch_pkg::OP_PLACE);
                        g_rd_en       = 1'b1;
                        state_in      = S_CELL;
                     end else begin
                        rsp_status_in = urch_pkg::ST_INVALID;
                        rsp_row_in    = req_row;
                        rsp_col_in    = req_col;
                     end
                  end
                  urch_pkg::OP_UNDO, urch_pkg::OP_REDO: begin
                     if (req_count == '0) begin
                        rsp_status_in = urch_pkg::ST_OK;
                     end else if (avail == '0) begin
                        rsp_status_in = urch_pkg::ST_NONE;
                        rsp_short_in  = 1'b1;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        is_undo_in    = (req_op == urch_pkg::OP_UNDO);
                        nsteps_in     = nsel[NW-1:0];
                        step_in       = NW'(1);
                        short_in      = (avail < count_w);
                        hist_rd_en    = 1'b1;
                        state_in      = S_HIST;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_CELL: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = urch_pkg::ST_OK;
            rsp_row_in    = row_ff;
            rsp_col_in    = col_ff;
            rsp_before_in = g_rd_data;
            rsp_after_in  = g_rd_data;
            rsp_step_in   = '0;
            rsp_short_in  = 1'b0;
            rsp_last_in   = 1'b1;
            if (is_place_ff) begin
               if (cursor_ff == CW'(HISTORY_DEPTH)) begin
                  // History full: nothing is recorded and the redo tail stays.
                  rsp_status_in = urch_pkg::ST_FULL;
               end else begin
                  // Recording at the cursor drops every redo entry above it.
                  hist_wr_en   = 1'b1;
                  g_wr_en      = 1'b1;
                  cursor_in    = cursor_ff + CW'(1);
                  length_in    = cursor_ff + CW'(1);
                  rsp_after_in = val_ff;
               end
            end
            state_in = S_IDLE;
         end

         S_HIST: begin
            ent_row_in = hist_rdata_ff[urch_pkg::ENTRY_W-1 -: CRD];
            ent_col_in = hist_rdata_ff[urch_pkg::ENTRY_W-CRD-1 -: CRD];
            ent_old_in = hist_rdata_ff[2*VW-1 -: VW];
            ent_new_in = hist_rdata_ff[VW-1:0];
            idx_in     = cell_index(ent_row_in, ent_col_in);
            g_rd_en    = 1'b1;
            g_rd_idx   = idx_in;
            state_in   = S_GRID;
         end

         S_GRID: begin
            g_wr_en       = 1'b1;
            g_wr_data     = step_after;
            rsp_strobe_in = 1'b1;
            rsp_status_in = urch_pkg::ST_OK;
            rsp_row_in    = ent_row_ff;
            rsp_col_in    = ent_col_ff;
            rsp_before_in = g_rd_data;
            rsp_after_in  = step_after;
            rsp_step_in   = step_ff;
            rsp_short_in  = short_ff;
            rsp_last_in   = step_done;
            cursor_in     = is_undo_ff ? (cursor_ff - CW'(1)) : (cursor_ff + CW'(1));
            if (step_done) begin
               state_in = S_IDLE;
            end else begin
               // The history read for the next step uses the moved cursor.
               step_in      = step_ff + NW'(1);
               hist_rd_en   = 1'b1;
               hist_rd_addr = is_undo_ff ? AW'(cursor_in - CW'(1)) : AW'(cursor_in);
               state_in     = S_HIST;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_ff     <= '0;
         length_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         length_ff     <= length_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      is_place_ff   <= is_place_in;
      is_undo_ff    <= is_undo_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      nsteps_ff     <= nsteps_in;
      step_ff       <= step_in;
      short_ff      <= short_in;
      ent_row_ff    <= ent_row_in;
      ent_col_ff    <= ent_col_in;
      ent_old_ff    <= ent_old_in;
      ent_new_ff    <= ent_new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_before_ff <= rsp_before_in;
      rsp_after_ff  <= rsp_after_in;
      rsp_step_ff   <= rsp_step_in;
      rsp_short_ff  <= rsp_short_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // History memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (hist_wr_en) begin
         hist_mem[hist_wr_addr] <= hist_wr_data;
      end
      if (hist_rd_en) begin
         hist_rdata_ff <= hist_mem[hist_rd_addr];
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_cell_row     = rsp_row_ff;
   assign rsp_cell_col     = rsp_col_ff;
   assign rsp_value_before = rsp_before_ff;
   assign rsp_value_after  = rsp_after_ff;
   assign rsp_step_number  = rsp_step_ff;
   assign rsp_ran_short    = rsp_short_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== rtl/core/urch_checker.sv =====
module urch_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          busy,
   input  logic                          rsp_strobe,
   input  logic [urch_pkg::STATUS_W-1:0] rsp_status,
   input  logic [urch_pkg::COUNT_W-1:0]  rsp_step_number,
   input  logic                          rsp_last
);

   // Reset leaves the block idle with no word pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   // A run that is not finished keeps new requests out.
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("block idle in the middle of a run");

   // Only successful run steps come in groups; every other word closes its request.
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != urch_pkg::ST_OK) |-> rsp_last)
      else $error("error word without last mark");

   // After a run step that is not the last, the strobe drops and then the next step follows with the next step number.
   a_step_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> (!rsp_strobe ##1
         (rsp_strobe && rsp_step_number == $past(rsp_step_number, 2) + 6'd1)))
      else $error("run step missing or out of sequence");

endmodule

bind undo_redo_cell_history urch_checker u_urch_checker (
   .clock           (clock),
   .reset           (reset),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_step_number (rsp_step_number),
   .rsp_last        (rsp_last)
);

// ===== verif/urch_grid_checker.sv =====
`timescale 1ns / 100ps

module urch_grid_checker #(
   parameter int unsigned HISTORY_DEPTH = 256,
   parameter int unsigned GRID_SIDE     = 9
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [urch_pkg::OP_W-1:0]     req_op,
   input  logic [urch_pkg::COORD_W-1:0]  req_row,
   input  logic [urch_pkg::COORD_W-1:0]  req_col,
   input  logic [urch_pkg::VALUE_W-1:0]  req_new_value,
   input  logic [urch_pkg::COUNT_W-1:0]  req_count,
   input  logic                          rsp_strobe,
   input  logic [urch_pkg::STATUS_W-1:0] rsp_status,
   input  logic [urch_pkg::COORD_W-1:0]  rsp_cell_row,
   input  logic [urch_pkg::COORD_W-1:0]  rsp_cell_col,
   input  logic [urch_pkg::VALUE_W-1:0]  rsp_value_before,
   input  logic [urch_pkg::VALUE_W-1:0]  rsp_value_after,
   input  logic [urch_pkg::COUNT_W-1:0]  rsp_step_number,
   input  logic                          rsp_ran_short,
   input  logic                          rsp_last,
   output int                            error_count,
   output int                            words_pending,
   output int                            undo_depth
);

   import urch_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COORD_W-1:0]  cell_row;
      logic [COORD_W-1:0]  cell_col;
      logic [VALUE_W-1:0]  value_before;
      logic [VALUE_W-1:0]  value_after;
      logic [COUNT_W-1:0]  step_number;
      logic                ran_short;
      logic                last;
   } grid_word_type;

   // Shadow of the grid and of the change log, with the applied and total counts.
   logic [VALUE_W-1:0] grid_shadow [GRID_SIDE*GRID_SIDE];
   logic [ENTRY_W-1:0] change_log [HISTORY_DEPTH];
   int unsigned        log_cursor;
   int unsigned        log_length;
   grid_word_type      expected_words [$];
   int                 errs;

   function automatic void push_word(logic [STATUS_W-1:0] status,
                                     logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                     logic [VALUE_W-1:0] vb, logic [VALUE_W-1:0] va,
                                     logic [COUNT_W-1:0] step, logic rs, logic lst);
      grid_word_type w;
      w.status       = status;
      w.cell_row     = r;
      w.cell_col     = c;
      w.value_before = vb;
      w.value_after  = va;
      w.step_number  = step;
      w.ran_short    = rs;
      w.last         = lst;
      expected_words.push_back(w);
   endfunction

   function automatic void apply_request(logic [OP_W-1:0] op, logic [COORD_W-1:0] r,
                                         logic [COORD_W-1:0] c, logic [VALUE_W-1:0] v,
                                         logic [COUNT_W-1:0] cnt);
      int unsigned        idx;
      int unsigned        avail;
      int unsigned        steps;
      int unsigned        pos;
      logic [ENTRY_W-1:0] entry;
      logic [VALUE_W-1:0] old_v;
      logic [VALUE_W-1:0] new_v;
      logic [COORD_W-1:0] er;
      logic [COORD_W-1:0] ec;
      logic               is_undo;
      logic               cut_short;
      if (op == OP_PLACE) begin
         if (r >= GRID_SIDE || c >= GRID_SIDE || v > GRID_SIDE) begin
            push_word(ST_INVALID, r, c, '0, '0, '0, 1'b0, 1'b1);
            return;
         end
         idx   = r * GRID_SIDE + c;
         old_v = grid_shadow[idx];
         if (log_cursor >= HISTORY_DEPTH) begin
            push_word(ST_FULL, r, c, old_v, old_v, '0, 1'b0, 1'b1);
            return;
         end
         change_log[log_cursor] = {r, c, old_v, v};
         log_cursor++;
         log_length = log_cursor;
         grid_shadow[idx] = v;
         push_word(ST_OK, r, c, old_v, v, '0, 1'b0, 1'b1);
         return;
      end
      if (op == OP_READ) begin
         if (r >= GRID_SIDE || c >= GRID_SIDE) begin
            push_word(ST_INVALID, r, c, '0, '0, '0, 1'b0, 1'b1);
            return;
         end
         old_v = grid_shadow[r * GRID_SIDE + c];
         push_word(ST_OK, r, c, old_v, old_v, '0, 1'b0, 1'b1);
         return;
      end
      if (cnt == 0) begin
         push_word(ST_OK, '0, '0, '0, '0, '0, 1'b0, 1'b1);
         return;
      end
      is_undo = (op == OP_UNDO);
      avail   = is_undo ? log_cursor : log_length - log_cursor;
      if (avail == 0) begin
         push_word(ST_NONE, '0, '0, '0, '0, '0, 1'b1, 1'b1);
         return;
      end
      steps     = (avail < cnt) ? avail : cnt;
      cut_short = (steps < cnt);
      for (int unsigned i = 0; i < steps; i++) begin
         if (is_undo) begin
            log_cursor--;
            pos = log_cursor;
         end else begin
            pos = log_cursor;
            log_cursor++;
         end
         entry = change_log[pos];
         er    = entry[ENTRY_W-1 -: COORD_W];
         ec    = entry[2*VALUE_W +: COORD_W];
         idx   = er * GRID_SIDE + ec;
         old_v = grid_shadow[idx];
         new_v = is_undo ? entry[VALUE_W +: VALUE_W] : entry[0 +: VALUE_W];
         grid_shadow[idx] = new_v;
         push_word(ST_OK, er, ec, old_v, new_v, COUNT_W'(i + 1), cut_short,
                   (i + 1 == steps));
      end
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errs++;
      end
   endfunction

   initial errs = 0;

   always @(posedge clock) begin : watch
      grid_word_type want;
      if (reset) begin
         foreach (grid_shadow[i]) grid_shadow[i] = '0;
         log_cursor = 0;
         log_length = 0;
         expected_words.delete();
      end else begin
         // Words from earlier requests are checked before this edge's request is predicted.
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: status %0d row %0d col %0d",
                      rsp_status, rsp_cell_row, rsp_cell_col);
               errs++;
            end else begin
               want = expected_words.pop_front();
               check_field("rsp_status", 8'(want.status), 8'(rsp_status));
               check_field("rsp_cell_row", 8'(want.cell_row), 8'(rsp_cell_row));
               check_field("rsp_cell_col", 8'(want.cell_col), 8'(rsp_cell_col));
               check_field("rsp_value_before", 8'(want.value_before),
                           8'(rsp_value_before));
               check_field("rsp_value_after", 8'(want.value_after), 8'(rsp_value_after));
               check_field("rsp_step_number", 8'(want.step_number), 8'(rsp_step_number));
               check_field("rsp_ran_short", 8'(want.ran_short), 8'(rsp_ran_short));
               check_field("rsp_last", 8'(want.last), 8'(rsp_last));
            end
         end
         if (start && !busy)
            apply_request(req_op, req_row, req_col, req_new_value, req_count);
      end
      error_count   <= errs;
      words_pending <= expected_words.size();
      undo_depth    <= log_cursor;
   end

endmodule

// ===== verif/tb_undo_redo_cell_history.sv =====
`timescale 1ns / 100ps

module tb_undo_redo_cell_history;

   import urch_pkg::*;

   localparam int unsigned HISTORY_DEPTH = 256;
   localparam int unsigned GRID_SIDE     = 9;

   // The longest stretch without any accepted word is a long sender gap plus
   // the time the block takes to answer, so this bound leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 2000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_op;
   logic [COORD_W-1:0]  req_row;
   logic [COORD_W-1:0]  req_col;
   logic [VALUE_W-1:0]  req_new_value;
   logic [COUNT_W-1:0]  req_count;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [COORD_W-1:0]  rsp_cell_row;
   logic [COORD_W-1:0]  rsp_cell_col;
   logic [VALUE_W-1:0]  rsp_value_before;
   logic [VALUE_W-1:0]  rsp_value_after;
   logic [COUNT_W-1:0]  rsp_step_number;
   logic                rsp_ran_short;
   logic                rsp_last;

   int error_count;
   int words_pending;
   int undo_depth;
   int stall_cycles;

   // When set, the sender presents words back to back without gaps.
   bit no_idle;

   undo_redo_cell_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .GRID_SIDE     (GRID_SIDE)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_new_value    (req_new_value),
      .req_count        (req_count),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_cell_col     (rsp_cell_col),
      .rsp_value_before (rsp_value_before),
      .rsp_value_after  (rsp_value_after),
      .rsp_step_number  (rsp_step_number),
      .rsp_ran_short    (rsp_ran_short),
      .rsp_last         (rsp_last)
   );

   // The checker watches both channels, keeps its own copy of the grid and the
   // change log, and reports the error count, the number of words still owed
   // and its view of the undo depth, which the fill phase below steers by.
   urch_grid_checker #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .GRID_SIDE     (GRID_SIDE)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_new_value    (req_new_value),
      .req_count        (req_count),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_cell_row     (rsp_cell_row),
      .rsp_cell_col     (rsp_cell_col),
      .rsp_value_before (rsp_value_before),
      .rsp_value_after  (rsp_value_after),
      .rsp_step_number  (rsp_step_number),
      .rsp_ran_short    (rsp_ran_short),
      .rsp_last         (rsp_last),
      .error_count      (error_count),
      .words_pending    (words_pending),
      .undo_depth       (undo_depth)
   );

   always #5 clock = ~clock;

   // The watchdog counts cycles in which neither a request nor a result word
   // is accepted, and gives up once that count reaches the limit.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_undo_redo_cell_history: errors");
            $finish;
         end
      end
   end

   // Most gaps are empty or short; a few are long enough that the block runs
   // dry and sits idle for a while.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Presents one request word and returns at the falling edge after it was
   // accepted. The task is always entered at a falling edge. Start is lowered
   // only for a gap, so it never falls and rises within one time step.
   task automatic issue(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] row,
                        input logic [COORD_W-1:0] col, input logic [VALUE_W-1:0] val,
                        input logic [COUNT_W-1:0] cnt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_op        <= op;
      req_row       <= row;
      req_col       <= col;
      req_new_value <= val;
      req_count     <= cnt;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Holds the sender off until every expected word has come back. Every
   // request produces at least one word, so an empty queue means the block
   // has finished.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
   endtask

   // One random request. Places and reads mostly use legal coordinates and
   // digits; with the given percentage the fields span their whole width.
   // Undo and redo mostly use short runs so that the cursor wanders around.
   task automatic random_request(input int bad_pct);
      int                 sel;
      int                 pick;
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [VALUE_W-1:0] val;
      logic [COUNT_W-1:0] cnt;
      sel = $urandom_range(0, 99);
      if (sel < 45)
         op = OP_PLACE;
      else if (sel < 65)
         op = OP_UNDO;
      else if (sel < 85)
         op = OP_REDO;
      else
         op = OP_READ;
      if (op == OP_PLACE || op == OP_READ) begin
         cnt = COUNT_W'($urandom);
         if ($urandom_range(0, 99) < bad_pct) begin
            row = COORD_W'($urandom);
            col = COORD_W'($urandom);
            val = VALUE_W'($urandom);
         end else begin
            row = COORD_W'($urandom_range(0, GRID_SIDE - 1));
            col = COORD_W'($urandom_range(0, GRID_SIDE - 1));
            val = VALUE_W'($urandom_range(0, GRID_SIDE));
         end
      end else begin
         row  = COORD_W'($urandom);
         col  = COORD_W'($urandom);
         val  = VALUE_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 8)
            cnt = '0;
         else if (pick < 75)
            cnt = COUNT_W'($urandom_range(1, 4));
         else
            cnt = COUNT_W'($urandom_range(5, 63));
      end
      issue(op, row, col, val, cnt);
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_op        = OP_PLACE;
      req_row       = '0;
      req_col       = '0;
      req_new_value = '0;
      req_count     = '0;
      no_idle       = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. The grid starts empty and the history holds nothing,
      // so the first undo and redo both find no step to take.
      issue(OP_READ, 4'd0, 4'd0, 4'd0, 6'd0);
      issue(OP_READ, 4'd15, 4'd15, 4'd15, 6'd63);
      issue(OP_READ, 4'd8, 4'd9, 4'd0, 6'd0);
      issue(OP_UNDO, 4'd0, 4'd0, 4'd0, 6'd5);
      issue(OP_REDO, 4'd0, 4'd0, 4'd0, 6'd3);
      issue(OP_UNDO, 4'd0, 4'd0, 4'd0, 6'd0);
      issue(OP_REDO, 4'd0, 4'd0, 4'd0, 6'd0);
      // Bad row, bad column and digits past the grid side are all rejected.
      issue(OP_PLACE, 4'd9, 4'd0, 4'd1, 6'd0);
      issue(OP_PLACE, 4'd0, 4'd15, 4'd1, 6'd0);
      issue(OP_PLACE, 4'd4, 4'd4, 4'd10, 6'd0);
      issue(OP_PLACE, 4'd4, 4'd4, 4'd15, 6'd63);
      // Legal places, including the corner cells and the largest digit.
      issue(OP_PLACE, 4'd0, 4'd0, 4'd9, 6'd0);
      issue(OP_PLACE, 4'd8, 4'd8, 4'd0, 6'd0);
      issue(OP_PLACE, 4'd8, 4'd8, 4'd5, 6'd0);
      issue(OP_PLACE, 4'd0, 4'd0, 4'd1, 6'd0);
      issue(OP_READ, 4'd8, 4'd8, 4'd0, 6'd0);
      // Partial undo, then runs that ask for more steps than exist.
      issue(OP_UNDO, 4'd0, 4'd0, 4'd0, 6'd2);
      issue(OP_REDO, 4'd0, 4'd0, 4'd0, 6'd63);
      issue(OP_UNDO, 4'd0, 4'd0, 4'd0, 6'd63);
      issue(OP_REDO, 4'd0, 4'd0, 4'd0, 6'd1);
      // A place in the middle of the history drops the redo entries.
      issue(OP_PLACE, 4'd3, 4'd7, 4'd7, 6'd0);
      issue(OP_REDO, 4'd0, 4'd0, 4'd0, 6'd5);
      issue(OP_READ, 4'd0, 4'd0, 4'd0, 6'd0);
      issue(OP_UNDO, 4'd0, 4'd0, 4'd0, 6'd1);
      drain();

      // Random mix with a share of malformed fields.
      repeat (80) random_request(15);
      drain();

      // Fill the history to its end with legal places. The first half goes
      // back to back; the rest uses the normal gaps.
      no_idle = 1'b1;
      while (undo_depth < HISTORY_DEPTH) begin
         if (undo_depth >= HISTORY_DEPTH / 2)
            no_idle = 1'b0;
         issue(OP_PLACE, COORD_W'($urandom_range(0, GRID_SIDE - 1)),
               COORD_W'($urandom_range(0, GRID_SIDE - 1)),
               VALUE_W'($urandom_range(0, GRID_SIDE)), COUNT_W'($urandom));
      end

      // With the history full a legal place is refused and changes nothing,
      // while a malformed one is still reported as invalid. A redo finds no step;
      // full-length undo and redo runs then walk the cursor without running short.
      issue(OP_PLACE, 4'd2, 4'd3, 4'd4, 6'd0);
      issue(OP_PLACE, 4'd1, 4'd1, 4'd12, 6'd0);
      issue(OP_PLACE, 4'd11, 4'd2, 4'd3, 6'd0);
      issue(OP_REDO, 4'd0, 4'd0, 4'd0, 6'd7);
      issue(OP_UNDO, 4'd0, 4'd0, 4'd0, 6'd63);
      issue(OP_UNDO, 4'd0, 4'd0, 4'd0, 6'd63);
      issue(OP_REDO, 4'd0, 4'd0, 4'd0, 6'd63);
      issue(OP_UNDO, 4'd0, 4'd0, 4'd0, 6'd0);
      issue(OP_READ, 4'd5, 4'd5, 4'd0, 6'd0);
      issue(OP_PLACE, 4'd5, 4'd5, 4'd9, 6'd0);
      issue(OP_REDO, 4'd0, 4'd0, 4'd0, 6'd4);

      repeat (30) random_request(20);
      drain();

      // Let the block settle before the verdict.
      repeat (8) @(negedge clock);
      if (error_count == 0) begin
         $display("tb_undo_redo_cell_history: clean");
      end else begin
         $display("tb_undo_redo_cell_history: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/urch_pkg.sv
rtl/core/urch_grid.sv
rtl/core/undo_redo_cell_history.sv
rtl/core/urch_checker.sv
verif/urch_grid_checker.sv
verif/tb_undo_redo_cell_history.sv
